/* rtl/ddos_pkg.sv */
// Package for the differential-drive odometry step core.
// Request payload structs, register codes and fixed-point constants. No dependencies.
package ddos_pkg;

  typedef struct packed {
    logic               command;
    logic signed [31:0] left_speed;
    logic signed [31:0] right_speed;
    logic signed [31:0] vertical_speed;
    logic signed [31:0] turn_echo;
    logic               speed_valid;
    logic               jump_request;
    logic signed [31:0] anchor_x;
    logic signed [31:0] anchor_y;
    logic signed [31:0] anchor_z;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] speed_x;
    logic signed [31:0] speed_y;
    logic signed [31:0] speed_z;
    logic signed [31:0] wheel_roll_rate;
    logic        [30:0] hop_height;
    logic signed [31:0] reported_turn;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_z;
  } out_req_t;

  localparam logic [2:0] REG_STEP    = 3'd0;
  localparam logic [2:0] REG_FLOOR   = 3'd1;
  localparam logic [2:0] REG_CEILING = 3'd2;
  localparam logic [2:0] REG_START_X = 3'd3;
  localparam logic [2:0] REG_START_Y = 3'd4;
  localparam logic [2:0] REG_START_Z = 3'd5;

  localparam int CORDIC_STEPS = 30;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;

  function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
    logic signed [33:0] r;
    begin
      case (i)
        5'd0: r = 34'sd536870912;  5'd1: r = 34'sd316933406;
        5'd2: r = 34'sd167458907;  5'd3: r = 34'sd85004756;
        5'd4: r = 34'sd42667331;   5'd5: r = 34'sd21354465;
        5'd6: r = 34'sd10679838;   5'd7: r = 34'sd5340245;
        5'd8: r = 34'sd2670163;    5'd9: r = 34'sd1335087;
        5'd10: r = 34'sd667544;    5'd11: r = 34'sd333772;
        5'd12: r = 34'sd166886;    5'd13: r = 34'sd83443;
        5'd14: r = 34'sd41722;     5'd15: r = 34'sd20861;
        5'd16: r = 34'sd10430;     5'd17: r = 34'sd5215;
        5'd18: r = 34'sd2608;      5'd19: r = 34'sd1304;
        5'd20: r = 34'sd652;       5'd21: r = 34'sd326;
        5'd22: r = 34'sd163;       5'd23: r = 34'sd81;
        5'd24: r = 34'sd41;        5'd25: r = 34'sd20;
        5'd26: r = 34'sd10;        5'd27: r = 34'sd5;
        5'd28: r = 34'sd3;         5'd29: r = 34'sd1;
        default: r = 34'sd0;
      endcase
      return r;
    end
  endfunction

endpackage

/* rtl/ddos_serial_mul.sv */
// Shift-add multiplier, one multiplier bit per cycle, signed 34 x 34 to 68 bits.
// Uses ddos_pkg for nothing beyond the common style; standalone.
module ddos_serial_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [33:0] a,
  input  logic signed [33:0] b,
  output logic               done,
  output logic signed [67:0] product
);
  logic [5:0]         count;
  logic               busy;
  logic signed [67:0] acc;
  logic signed [67:0] mcand;
  logic [33:0]        mplier;

  // one partial product per cycle; top bit of b carries negative weight
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= '0;
        acc <= '0;
        mcand <= 68'(a);
        mplier <= b;
      end else if (busy) begin
        if (mplier[0]) begin
          if (count == 6'd33) acc <= acc - mcand;
          else acc <= acc + mcand;
        end
        mcand <= mcand <<< 1;
        mplier <= mplier >> 1;
        count <= count + 6'd1;
        if (count == 6'd33) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = acc;
endmodule

/* rtl/ddos_cordic.sv */
// Iterative rotation-mode CORDIC, one micro-rotation per cycle at Q4.30.
// Depends on ddos_pkg for the arctangent table and gain.
module ddos_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [33:0] cos_out,
  output logic signed [33:0] sin_out
);
  import ddos_pkg::*;

  logic               busy;
  logic               flip;
  logic [4:0]         step;
  logic signed [33:0] x, y, z;
  logic [31:0]        adj;
  logic               flip_now;
  logic signed [33:0] dx, dy;

  assign flip_now = adj[31];
  assign adj = angle + 32'h4000_0000;
  assign dx = y >>> step;
  assign dy = x >>> step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        flip <= flip_now;
        x <= CORDIC_GAIN;
        y <= '0;
        z <= 34'(signed'(flip_now ? angle + 32'h8000_0000 : angle));
      end else if (busy) begin
        if (!z[33]) begin
          x <= x - dx; y <= y + dy; z <= z - atan_turn(step);
        end else begin
          x <= x + dx; y <= y - dy; z <= z + atan_turn(step);
        end
        step <= step + 5'd1;
        if (step == 5'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign cos_out = flip ? -x : x;
  assign sin_out = flip ? -y : y;
endmodule

/* rtl/diff_drive_odometry_step_core.sv */
// Differential-drive odometry step core: top level sequencer, state and registers.
// Depends on ddos_pkg, ddos_serial_mul and ddos_cordic.
//
// An advance request that moves the robot runs, in order: a CORDIC on the held heading,
// eight passes through the shared bit-serial multiplier, a CORDIC on the half heading
// and a load of the output register. The next request is not taken until that result
// is loaded. A tick before motion is enabled only runs the half-heading CORDIC before
// giving its result. An anchor load writes the position and gives no result. Requests
// are held off while a finished result is stalled or a config write is offered. Config
// writes are taken only while no request is at work.
module diff_drive_odometry_step_core #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ddos_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ddos_pkg::out_req_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import ddos_pkg::*;

  localparam longint ONE_Q    = 64'sd1 <<< FRAC_BITS;
  localparam longint HUND_Q   = (ONE_Q + 50) / 100;
  localparam longint GRAV_Q   = (ONE_Q * 98 + 500) / 1000;
  localparam longint JUMP_Q   = ONE_Q * 4;
  localparam int     SH       = 32 + FRAC_BITS - ANGLE_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_COR1  = 4'd1;
  localparam logic [3:0] S_VX    = 4'd2;
  localparam logic [3:0] S_VY    = 4'd3;
  localparam logic [3:0] S_PX    = 4'd4;
  localparam logic [3:0] S_PY    = 4'd5;
  localparam logic [3:0] S_PZ    = 4'd6;
  localparam logic [3:0] S_JMP   = 4'd7;
  localparam logic [3:0] S_DYAW  = 4'd8;
  localparam logic [3:0] S_UNITS = 4'd9;
  localparam logic [3:0] S_COR2  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0] state;
  logic       launch;

  // configuration and state
  logic [15:0]        step_length;
  logic signed [31:0] floor_h, ceil_h, start_x, start_y, start_z;
  logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, roll_rate;
  logic signed [31:0] jump_h, climb;
  logic [ANGLE_BITS-1:0] heading;
  logic airborne, moving;
  in_req_t req;
  logic signed [31:0] mean, omega;
  logic signed [33:0] cos_h, sin_h;

  // shared units
  logic               mul_start, mul_done, cor_start, cor_done;
  logic signed [33:0] mul_a, mul_b, cor_c, cor_s;
  logic signed [67:0] mul_p;
  logic [31:0]        cor_angle;

  ddos_serial_mul u_mul (.clk, .rst, .start(mul_start), .a(mul_a), .b(mul_b),
                         .done(mul_done), .product(mul_p));
  ddos_cordic u_cor (.clk, .rst, .start(cor_start), .angle(cor_angle),
                     .done(cor_done), .cos_out(cor_c), .sin_out(cor_s));

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -68'sh8000_0000) return -32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] q15(input logic signed [33:0] v);
    logic signed [34:0] r;
    begin
      r = (35'(v) + 35'sd16384) >>> 15;
      if (r > 35'sd32767) return 16'sh7FFF;
      if (r < -35'sd32768) return -16'sh8000;
      return r[15:0];
    end
  endfunction

  logic [31:0]        head32;
  logic signed [67:0] rq, r30, rsh;
  logic signed [31:0] zsum, jsum;
  logic signed [32:0] ptmp;
  logic [ANGLE_BITS-1:0] heading_next;
  logic [31:0]        half32, half32_next;
  assign head32 = {heading, {(32 - ANGLE_BITS){1'b0}}};
  assign rq  = (mul_p + (68'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  assign r30 = (mul_p + (68'sd1 <<< 29)) >>> 30;
  assign rsh = (mul_p + (68'sd1 <<< (SH - 1))) >>> SH;
  assign zsum = sat32(68'(pos_z) + 68'(sat32(rq)));
  assign jsum = sat32(68'(jump_h) + 68'(sat32(rq)));
  assign ptmp = 33'(climb) - 33'(GRAV_Q);
  // half heading before and after the turn of this tick
  assign heading_next = heading + rsh[ANGLE_BITS-1:0];
  assign half32 = 32'(signed'(head32) >>> 1);
  assign half32_next = 32'(signed'({heading_next, {(32 - ANGLE_BITS){1'b0}}}) >>> 1);

  assign in_stall  = (state != S_IDLE) || launch || (out_valid && out_stall) || cfg_valid;
  assign cfg_ready = (state == S_IDLE) && !launch;

  // operand and start selection for the shared units
  always_comb begin
    mul_a = '0; mul_b = '0; mul_start = 1'b0;
    cor_start = 1'b0; cor_angle = head32;
    if (launch) begin
      cor_start = 1'b1;
      if (state == S_UNITS) cor_angle = half32;
    end
    if (cor_done && state == S_COR1) begin
      mul_start = 1'b1; mul_a = 34'(mean); mul_b = cor_c;
    end
    if (mul_done) begin
      mul_start = 1'b1;
      unique case (state)
        S_VX:    begin mul_a = 34'(mean); mul_b = sin_h; end
        S_VY:    begin mul_a = 34'(vel_x); mul_b = 34'(step_length); end
        S_PX:    begin mul_a = 34'(vel_y); mul_b = 34'(step_length); end
        S_PY:    begin mul_a = 34'(req.vertical_speed); mul_b = 34'(step_length); end
        S_PZ:    begin mul_a = 34'(sat32(68'(ptmp))); mul_b = 34'(HUND_Q); end
        S_JMP:   begin mul_a = 34'(omega); mul_b = 34'(step_length); end
        S_DYAW:  begin mul_a = 34'(sat32(rq)); mul_b = 34'(INV_TWO_PI_Q32); end
        S_UNITS: mul_start = 1'b0;
        default: mul_start = 1'b0;
      endcase
    end
    if (mul_done && state == S_UNITS) begin
      cor_start = 1'b1;
      cor_angle = half32_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; launch <= 1'b0; out_valid <= 1'b0;
      step_length <= 16'(HUND_Q);
      floor_h <= 32'((ONE_Q * 2 + 5) / 10);
      ceil_h <= 32'(ONE_Q);
      start_x <= 32'(ONE_Q); start_y <= 32'(ONE_Q); start_z <= 32'(ONE_Q);
      pos_x <= 32'(ONE_Q); pos_y <= 32'(ONE_Q); pos_z <= 32'(ONE_Q);
      vel_x <= '0; vel_y <= '0; vel_z <= '0; roll_rate <= '0;
      jump_h <= '0; climb <= '0; heading <= '0; airborne <= 1'b0; moving <= 1'b0;
    end else begin
      launch <= in_valid && !in_stall && !in_data.command;
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_STEP:    step_length <= cfg_data[15:0];
          REG_FLOOR:   floor_h <= cfg_data;
          REG_CEILING: ceil_h <= cfg_data;
          REG_START_X: begin start_x <= cfg_data; pos_x <= cfg_data; end
          REG_START_Y: begin start_y <= cfg_data; pos_y <= cfg_data; end
          REG_START_Z: begin start_z <= cfg_data; pos_z <= cfg_data; end
          default: ;
        endcase
      end
      // accept a request
      if (in_valid && !in_stall) begin
        req <= in_data;
        if (in_data.command) begin
          pos_x <= in_data.anchor_x; pos_y <= in_data.anchor_y;
          pos_z <= in_data.anchor_z;
        end else begin
          mean <= 32'((33'(in_data.left_speed) + 33'(in_data.right_speed)) >>> 1);
          omega <= sat32((68'(in_data.right_speed) - 68'(in_data.left_speed)) <<< 1);
          if (in_data.speed_valid || in_data.jump_request || moving) begin
            moving <= 1'b1;
            if (in_data.jump_request && !airborne) begin
              airborne <= 1'b1; climb <= 32'(JUMP_Q);
            end
            state <= S_COR1;
          end else begin
            state <= S_UNITS;
          end
        end
      end
      unique case (state)
        S_IDLE: ;
        S_COR1: if (cor_done) begin
          sin_h <= cor_s; state <= S_VX;
          roll_rate <= mean; vel_z <= req.vertical_speed;
        end
        S_VX: if (mul_done) begin vel_x <= sat32(r30); state <= S_VY; end
        S_VY: if (mul_done) begin vel_y <= sat32(r30); state <= S_PX; end
        S_PX: if (mul_done) begin
          pos_x <= sat32(68'(pos_x) + 68'(sat32(rq))); state <= S_PY;
        end
        S_PY: if (mul_done) begin
          pos_y <= sat32(68'(pos_y) + 68'(sat32(rq))); state <= S_PZ;
        end
        S_PZ: if (mul_done) begin
          if (zsum < floor_h || floor_h > ceil_h) pos_z <= floor_h;
          else if (zsum > ceil_h) pos_z <= ceil_h;
          else pos_z <= zsum;
          if (airborne) climb <= sat32(68'(ptmp));
          state <= S_JMP;
        end
        S_JMP: if (mul_done) begin
          if (airborne) begin
            if (jsum <= 0) begin jump_h <= '0; airborne <= 1'b0; end
            else jump_h <= jsum;
          end else jump_h <= '0;
          state <= S_DYAW;
        end
        S_DYAW: if (mul_done) state <= S_UNITS;
        S_UNITS: begin
          // idle ticks skip straight to the half-angle rotation (launch started it)
          if (mul_done) begin
            heading <= heading_next;
            state <= S_COR2;
          end else if (!moving && cor_done) begin
            cos_h <= cor_c; sin_h <= cor_s; state <= S_OUT;
          end
        end
        S_COR2: if (cor_done) begin cos_h <= cor_c; sin_h <= cor_s; state <= S_OUT; end
        S_OUT: if (!out_valid || !out_stall) begin
          out_valid <= 1'b1;
          out_data <= '{out_x: pos_x, out_y: pos_y, out_z: pos_z, speed_x: vel_x,
                        speed_y: vel_y, speed_z: vel_z, wheel_roll_rate: roll_rate,
                        hop_height: jump_h[30:0], reported_turn: req.turn_echo,
                        quat_w: q15(cos_h), quat_z: q15(sin_h)};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  property p_no_accept_busy;
    @(posedge clk) disable iff (rst) (state != S_IDLE) |-> in_stall;
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("accepted while busy");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |-> (state == S_IDLE)) else $error("config while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(out_data)) else $error("result lost");
endmodule
